// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the 128-bit divider.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/u128div_pkg.sv -----
// Types and constants for the unsigned 128-bit divider.
// Depends on nothing; used by unsigned_128_bit_divider.
`default_nettype none

package u128div_pkg;

   localparam int HALF_WIDTH  = 64;
   localparam int DATA_WIDTH  = 2 * HALF_WIDTH;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic [COUNT_WIDTH-1:0] LAST_STEP = COUNT_WIDTH'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0]  ALL_ONES  = '1;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_BUSY,
      STATE_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- sv/unsigned_128_bit_divider.sv -----
// Unsigned 128-bit divider: a radix-2 restoring divider around one shared subtractor.
// Depends on u128div_pkg and assert_macros.svh.
//
// Usage:
// The req channel takes one item: dividend and divisor, each as two 64-bit halves.
// The rsp channel returns the quotient and remainder as 64-bit halves plus a
// divide_by_zero flag. Both channels use valid and ready.
// A nonzero divisor runs the subtract-and-shift loop, one quotient bit per
// cycle through a single 130-bit subtractor, until all 128 bits are done; the
// finish state then hands the item to the output register, which raises
// rsp_valid. A zero divisor skips the loop and goes straight to the finish state:
// rsp_valid rises with all-ones quotient and remainder and the flag set.
// req_ready is high only in the idle state, so a new item is taken only once the
// last one has left the finish state.
// The result sits in an output register, so a new item is accepted and computed
// while an earlier result still waits. If that result has not been taken when the
// next one finishes, the divider holds in its finish state until rsp_ready.
// Reset clears the sequencer and rsp_valid; any result not yet taken is dropped.
`default_nettype none

`include "assert_macros.svh"

module unsigned_128_bit_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_dividend_hi,
   input  wire logic [63:0] req_dividend_lo,
   input  wire logic [63:0] req_divisor_hi,
   input  wire logic [63:0] req_divisor_lo,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_quotient_hi,
   output logic [63:0]      rsp_quotient_lo,
   output logic [63:0]      rsp_remainder_hi,
   output logic [63:0]      rsp_remainder_lo,
   output logic             rsp_divide_by_zero
);

   localparam int HW = u128div_pkg::HALF_WIDTH;
   localparam int DW = u128div_pkg::DATA_WIDTH;
   localparam int CW = u128div_pkg::COUNT_WIDTH;

   u128div_pkg::state_type state_ff, state_in;

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] div_ff, div_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dbz_ff, dbz_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_quo_ff;
   logic [DW-1:0] rsp_rem_ff;
   logic          rsp_dbz_ff;

   logic          accept;
   logic          load_out;
   logic          divisor_zero;
   logic [DW-1:0] shifted;
   logic [DW+1:0] diff;
   logic          ge;

   assign accept       = req_valid && req_ready;
   assign divisor_zero = (req_divisor_hi == '0) && (req_divisor_lo == '0);

   // One step: shift the next dividend bit into the partial remainder and try
   // to subtract the divisor. The bit shifted out of the remainder is kept.
   assign shifted = {rem_ff[DW-2:0], quo_ff[DW-1]};
   assign diff    = {1'b0, rem_ff[DW-1], shifted} - {2'b00, div_ff};
   assign ge      = !diff[DW+1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         u128div_pkg::STATE_IDLE: begin
            if (req_valid) begin
               state_in = divisor_zero ? u128div_pkg::STATE_FINISH
                                       : u128div_pkg::STATE_BUSY;
            end
         end
         u128div_pkg::STATE_BUSY: begin
            if (count_ff == u128div_pkg::LAST_STEP) begin
               state_in = u128div_pkg::STATE_FINISH;
            end
         end
         u128div_pkg::STATE_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = u128div_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = u128div_pkg::STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == u128div_pkg::STATE_IDLE);
      load_out  = (state_ff == u128div_pkg::STATE_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      dbz_in   = dbz_ff;
      if (accept) begin
         div_in   = {req_divisor_hi, req_divisor_lo};
         count_in = '0;
         dbz_in   = divisor_zero;
         if (divisor_zero) begin
            rem_in = u128div_pkg::ALL_ONES;
            quo_in = u128div_pkg::ALL_ONES;
         end else begin
            rem_in = '0;
            quo_in = {req_dividend_hi, req_dividend_lo};
         end
      end else if (state_ff == u128div_pkg::STATE_BUSY) begin
         rem_in   = ge ? diff[DW-1:0] : shifted;
         quo_in   = {quo_ff[DW-2:0], ge};
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u128div_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      count_ff <= count_in;
      dbz_ff   <= dbz_in;
      if (load_out) begin
         rsp_quo_ff <= quo_ff;
         rsp_rem_ff <= rem_ff;
         rsp_dbz_ff <= dbz_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient_hi    = rsp_quo_ff[DW-1:HW];
   assign rsp_quotient_lo    = rsp_quo_ff[HW-1:0];
   assign rsp_remainder_hi   = rsp_rem_ff[DW-1:HW];
   assign rsp_remainder_lo   = rsp_rem_ff[HW-1:0];
   assign rsp_divide_by_zero = rsp_dbz_ff;

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != u128div_pkg::STATE_IDLE)
   `ASSERT_NEXT(a_last_step_finishes, clock, reset,
      (state_ff == u128div_pkg::STATE_BUSY) && (count_ff == u128div_pkg::LAST_STEP),
      state_ff == u128div_pkg::STATE_FINISH)
   `ASSERT_SAME(a_remainder_below_divisor, clock, reset,
      (state_ff == u128div_pkg::STATE_FINISH) && !dbz_ff, rem_ff < div_ff)
   `ASSERT_SAME(a_zero_divisor_all_ones, clock, reset, rsp_valid && rsp_divide_by_zero,
      (rsp_quo_ff == u128div_pkg::ALL_ONES) && (rsp_rem_ff == u128div_pkg::ALL_ONES))

endmodule

`default_nettype wire
